### sv/mrs_pkg.sv
package mrs_pkg;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       tx_last;
      logic [2:0] event_res;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_STATION  = 3'd0,
      PH_FUNCTION = 3'd1,
      PH_HEADER   = 3'd2,
      PH_COUNT    = 3'd3,
      PH_DATA     = 3'd4,
      PH_CRC      = 3'd5
   } phase_type;

   typedef enum logic [3:0] {
      KIND_NONE     = 4'd0,
      KIND_EXC_FUNC = 4'd1,
      KIND_EXC_ADDR = 4'd2,
      KIND_EXC_DATA = 4'd3,
      KIND_BITS     = 4'd4,
      KIND_REGS     = 4'd5,
      KIND_ECHO     = 4'd6
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR    = 4'd0,
      ST_IDLE     = 4'd1,
      ST_DECODE   = 4'd2,
      ST_CM_ISSUE = 4'd3,
      ST_CM_HIGH  = 4'd4,
      ST_CM_WRITE = 4'd5,
      ST_BIT_READ = 4'd6,
      ST_BIT_TAKE = 4'd7,
      ST_REG_READ = 4'd8,
      ST_REG_TAKE = 4'd9,
      ST_EMIT     = 4'd10,
      ST_DONE     = 4'd11
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic capture;
      logic decode;
      logic cm_high;
      logic cm_write;
      logic bit_read;
      logic bit_take;
      logic reg_take;
      logic emit;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic op;
      logic commit_loop;
      logic kind_none;
      logic need_bits;
      logic need_reg;
      logic cm_is_regs;
      logic cm_last;
      logic bit_last;
      logic out_free;
   } status_type;

   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_QUEUED  = 3'd1;
   localparam logic [2:0] EV_CRC     = 3'd2;
   localparam logic [2:0] EV_OTHER   = 3'd3;
   localparam logic [2:0] EV_BUSY    = 3'd4;
   localparam logic [2:0] EV_SKIPPED = 3'd5;

   localparam logic [7:0] FC_READ_COILS    = 8'h01;
   localparam logic [7:0] FC_READ_DISCRETE = 8'h02;
   localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
   localparam logic [7:0] FC_READ_INPUT    = 8'h04;
   localparam logic [7:0] FC_WRITE_COIL    = 8'h05;
   localparam logic [7:0] FC_WRITE_REG     = 8'h06;
   localparam logic [7:0] FC_WRITE_COILS   = 8'h0F;
   localparam logic [7:0] FC_WRITE_REGS    = 8'h10;

   localparam logic [15:0] LIM_READ_BITS  = 16'd2000;
   localparam logic [15:0] LIM_READ_REGS  = 16'd125;
   localparam logic [15:0] LIM_WRITE_BITS = 16'd1968;
   localparam logic [15:0] LIM_WRITE_REGS = 16'd123;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0]  EXC_FLAG = 8'h80;
   localparam logic [7:0]  STATION_ANY = 8'hFF;
   localparam logic [7:0]  COIL_ON = 8'hFF;

   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

### sv/modbus_rtu_slave_engine.sv
// one request at a time: a received byte passes decode and done to its response, and a
// committing multi-write frame loops issue, write per coil or issue, high, write per
// register into the stores; a pull passes decode, emit and done (no emit when idle),
// plus reg read and take for a register data byte, or 8 coil reads for a coil data byte
// the response register lets the next request in while the last response waits
// synchronous reset; the holding and coil stores are then swept to zero, one entry a cycle,
// through all AREA_WORDS entries, during which no request is taken
module modbus_rtu_slave_engine #(
   parameter int AREA_WORDS = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mrs_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mrs_pkg::rsp_type  rsp_data,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data
);
   mrs_pkg::cmd_type    cmd;
   mrs_pkg::status_type status;
   logic                req_ready;

   mrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   mrs_datapath #(.AREA_WORDS(AREA_WORDS)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   assign req_stall = ~req_ready;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in work");

   a_last_is_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.tx_last |-> rsp_data.tx_valid)
      else $error("last flag without a response byte");

   a_event_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_res != mrs_pkg::EV_NONE |-> !rsp_data.tx_valid)
      else $error("receive event together with a response byte");
endmodule

### sv/mrs_ram.sv
module mrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [AW-1:0]            rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### sv/mrs_datapath.sv
module mrs_datapath #(
   parameter int AREA_WORDS = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mrs_pkg::cmd_type     cmd,
   output mrs_pkg::status_type  status,
   input  mrs_pkg::req_type     req_data,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output mrs_pkg::rsp_type     rsp_data
);
   localparam int AW = $clog2(AREA_WORDS);
   localparam logic [16:0]   AREA_LIMIT = 17'(AREA_WORDS);
   localparam logic [AW-1:0] CLEAR_LAST = AW'(AREA_WORDS - 1);

   logic [7:0]          own_station_ff, own_station_in;
   logic                op_ff;
   logic [7:0]          rx_ff;
   mrs_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]          station_ff, station_in;
   logic [7:0]          function_ff, function_in;
   logic [15:0]         address_ff, address_in;
   logic [15:0]         count_ff, count_in;
   logic [7:0]          total_ff, total_in;
   logic [7:0]          index_ff, index_in;
   logic [15:0]         rcrc_ff, rcrc_in;
   mrs_pkg::kind_type   kind_ff, kind_in;
   logic [7:0]          pos_ff, pos_in;
   logic [15:0]         xcrc_ff, xcrc_in;
   logic [10:0]         iter_ff, iter_in;
   logic [7:0]          acc_ff, acc_in;
   logic [7:0]          hold_ff;
   logic                bvalid_ff;
   logic [AW-1:0]       clear_ff;
   mrs_pkg::rsp_type    res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   mrs_pkg::rsp_type    rsp_data_ff;

   logic                known;
   logic [15:0]         crc_seed;
   logic [15:0]         crc_rx;
   logic [16:0]         area_sum;
   logic                over_area;
   logic                addr_out;
   logic [16:0]         bits_need;
   logic [16:0]         regs_need;
   logic                station_ok;
   logic                frame_end;
   logic                do_commit;
   mrs_pkg::kind_type   commit_kind;
   logic [2:0]          rx_event;
   logic [7:0]          len;
   logic [7:0]          jpos;
   logic [10:0]         bitnum;
   logic [7:0]          body;
   logic                recv_act;
   logic                wr_coil1;
   logic                wr_reg1;
   logic                cm_regs;

   logic                hold_we;
   logic [AW-1:0]       hold_waddr, hold_raddr;
   logic [15:0]         hold_wdata, hold_rdata;
   logic                coil_we;
   logic [AW-1:0]       coil_waddr, coil_raddr;
   logic [0:0]          coil_wdata, coil_rdata;
   logic                pay_we;
   logic [7:0]          pay_raddr, pay_rdata;

   function automatic logic range_bad(input logic [15:0] n, input logic [15:0] limit,
                                      input logic over);
      return (n == 16'd0) || (n > limit) || over;
   endfunction

   assign known = (rx_ff <= mrs_pkg::FC_WRITE_REG) || (rx_ff == mrs_pkg::FC_WRITE_COILS) ||
                  (rx_ff == mrs_pkg::FC_WRITE_REGS);
   assign crc_seed = ((phase_ff == mrs_pkg::PH_STATION) ||
                      (phase_ff == mrs_pkg::PH_FUNCTION && !known)) ? mrs_pkg::CRC_INIT : rcrc_ff;
   assign crc_rx    = mrs_pkg::crc_byte(crc_seed, rx_ff);
   assign area_sum  = {1'b0, address_ff} + {1'b0, count_ff};
   assign over_area = area_sum > AREA_LIMIT;
   assign addr_out  = {1'b0, address_ff} >= AREA_LIMIT;
   assign bits_need = ({1'b0, count_ff} + 17'd7) >> 3;
   assign regs_need = {count_ff, 1'b0};
   assign station_ok = (station_ff == 8'h00) || (station_ff == mrs_pkg::STATION_ANY) ||
                       (station_ff == own_station_ff);
   assign frame_end = (phase_ff == mrs_pkg::PH_CRC) && (index_ff == 8'd1);
   assign do_commit = frame_end && (crc_rx == 16'h0000) && station_ok;
   assign recv_act  = cmd.decode && !op_ff && (kind_ff == mrs_pkg::KIND_NONE);
   assign cm_regs   = function_ff == mrs_pkg::FC_WRITE_REGS;

   always_comb begin
      commit_kind = mrs_pkg::KIND_EXC_FUNC;
      case (function_ff)
         mrs_pkg::FC_READ_COILS, mrs_pkg::FC_READ_DISCRETE: begin
            commit_kind = range_bad(count_ff, mrs_pkg::LIM_READ_BITS, over_area) ?
                          mrs_pkg::KIND_EXC_ADDR : mrs_pkg::KIND_BITS;
         end
         mrs_pkg::FC_READ_HOLDING, mrs_pkg::FC_READ_INPUT: begin
            commit_kind = range_bad(count_ff, mrs_pkg::LIM_READ_REGS, over_area) ?
                          mrs_pkg::KIND_EXC_ADDR : mrs_pkg::KIND_REGS;
         end
         mrs_pkg::FC_WRITE_COIL, mrs_pkg::FC_WRITE_REG: begin
            commit_kind = addr_out ? mrs_pkg::KIND_EXC_ADDR : mrs_pkg::KIND_ECHO;
         end
         mrs_pkg::FC_WRITE_COILS: begin
            if (range_bad(count_ff, mrs_pkg::LIM_WRITE_BITS, over_area)) begin
               commit_kind = mrs_pkg::KIND_EXC_ADDR;
            end else if ({9'd0, total_ff} < bits_need) begin
               commit_kind = mrs_pkg::KIND_EXC_DATA;
            end else begin
               commit_kind = mrs_pkg::KIND_ECHO;
            end
         end
         mrs_pkg::FC_WRITE_REGS: begin
            if (range_bad(count_ff, mrs_pkg::LIM_WRITE_REGS, over_area)) begin
               commit_kind = mrs_pkg::KIND_EXC_ADDR;
            end else if ({9'd0, total_ff} < regs_need) begin
               commit_kind = mrs_pkg::KIND_EXC_DATA;
            end else begin
               commit_kind = mrs_pkg::KIND_ECHO;
            end
         end
         default: begin
            commit_kind = mrs_pkg::KIND_EXC_FUNC;
         end
      endcase
   end

   always_comb begin
      case (kind_ff)
         mrs_pkg::KIND_BITS: len = 8'd3 + bits_need[7:0];
         mrs_pkg::KIND_REGS: len = 8'd3 + {count_ff[6:0], 1'b0};
         mrs_pkg::KIND_ECHO: len = 8'd6;
         default:            len = 8'd3;
      endcase
   end

   assign jpos   = pos_ff - 8'd3;
   assign bitnum = {jpos, iter_ff[2:0]};

   always_comb begin
      body = acc_ff;
      if (pos_ff == 8'd0) begin
         body = station_ff;
      end else if (kind_ff inside {mrs_pkg::KIND_EXC_FUNC, mrs_pkg::KIND_EXC_ADDR,
                                   mrs_pkg::KIND_EXC_DATA}) begin
         body = (pos_ff == 8'd1) ? (function_ff | mrs_pkg::EXC_FLAG) : {4'h0, kind_ff};
      end else if (pos_ff == 8'd1) begin
         body = function_ff;
      end else if (kind_ff == mrs_pkg::KIND_ECHO) begin
         case (pos_ff)
            8'd2:    body = address_ff[15:8];
            8'd3:    body = address_ff[7:0];
            8'd4:    body = count_ff[15:8];
            default: body = count_ff[7:0];
         endcase
      end else if (pos_ff == 8'd2) begin
         body = (kind_ff == mrs_pkg::KIND_BITS) ? bits_need[7:0] : {count_ff[6:0], 1'b0};
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      station_in  = station_ff;
      function_in = function_ff;
      address_in  = address_ff;
      count_in    = count_ff;
      total_in    = total_ff;
      index_in    = index_ff;
      rcrc_in     = rcrc_ff;
      kind_in     = kind_ff;
      pos_in      = pos_ff;
      xcrc_in     = xcrc_ff;
      rx_event    = mrs_pkg::EV_NONE;
      if (recv_act) begin
         rcrc_in = crc_rx;
         case (phase_ff)
            mrs_pkg::PH_FUNCTION: begin
               if (known) begin
                  function_in = rx_ff;
                  phase_in    = mrs_pkg::PH_HEADER;
                  index_in    = 8'd0;
               end else begin
                  station_in = rx_ff;
                  rx_event   = mrs_pkg::EV_SKIPPED;
               end
            end
            mrs_pkg::PH_HEADER: begin
               case (index_ff[1:0])
                  2'd0:    address_in = {rx_ff, 8'h00};
                  2'd1:    address_in = {address_ff[15:8], rx_ff};
                  2'd2:    count_in   = {rx_ff, 8'h00};
                  default: count_in   = {count_ff[15:8], rx_ff};
               endcase
               index_in = index_ff + 8'd1;
               if (index_ff == 8'd3) begin
                  index_in = 8'd0;
                  phase_in = (function_ff == mrs_pkg::FC_WRITE_COILS || cm_regs) ?
                             mrs_pkg::PH_COUNT : mrs_pkg::PH_CRC;
               end
            end
            mrs_pkg::PH_COUNT: begin
               total_in = rx_ff;
               index_in = 8'd0;
               phase_in = (rx_ff != 8'd0) ? mrs_pkg::PH_DATA : mrs_pkg::PH_CRC;
            end
            mrs_pkg::PH_DATA: begin
               index_in = index_ff + 8'd1;
               if ({1'b0, index_ff} + 9'd1 >= {1'b0, total_ff}) begin
                  index_in = 8'd0;
                  phase_in = mrs_pkg::PH_CRC;
               end
            end
            mrs_pkg::PH_CRC: begin
               index_in = index_ff + 8'd1;
               if (frame_end) begin
                  index_in = 8'd0;
                  phase_in = mrs_pkg::PH_STATION;
                  if (crc_rx != 16'h0000) begin
                     rx_event = mrs_pkg::EV_CRC;
                  end else if (!station_ok) begin
                     rx_event = mrs_pkg::EV_OTHER;
                  end else begin
                     rx_event = mrs_pkg::EV_QUEUED;
                     kind_in  = commit_kind;
                     pos_in   = 8'd0;
                     xcrc_in  = mrs_pkg::CRC_INIT;
                  end
               end
            end
            default: begin
               station_in = rx_ff;
               phase_in   = mrs_pkg::PH_FUNCTION;
            end
         endcase
      end
      if (cmd.emit) begin
         if (pos_ff < len) begin
            xcrc_in = mrs_pkg::crc_byte(xcrc_ff, body);
            pos_in  = pos_ff + 8'd1;
         end else if (pos_ff == len) begin
            pos_in = pos_ff + 8'd1;
         end else begin
            kind_in = mrs_pkg::KIND_NONE;
            pos_in  = 8'd0;
         end
      end
   end

   always_comb begin
      res_in = res_ff;
      if (cmd.decode) begin
         res_in.tx_valid  = 1'b0;
         res_in.tx_byte   = 8'h00;
         res_in.tx_last   = 1'b0;
         res_in.event_res = op_ff ? mrs_pkg::EV_NONE :
                            ((kind_ff != mrs_pkg::KIND_NONE) ? mrs_pkg::EV_BUSY : rx_event);
      end
      if (cmd.emit) begin
         res_in.tx_valid  = 1'b1;
         res_in.tx_last   = 1'b0;
         res_in.event_res = mrs_pkg::EV_NONE;
         if (pos_ff < len) begin
            res_in.tx_byte = body;
         end else if (pos_ff == len) begin
            res_in.tx_byte = xcrc_ff[7:0];
         end else begin
            res_in.tx_byte = xcrc_ff[15:8];
            res_in.tx_last = 1'b1;
         end
      end
   end

   always_comb begin
      iter_in = iter_ff;
      acc_in  = acc_ff;
      if (cmd.decode) begin
         iter_in = 11'd0;
      end
      if (cmd.cm_write || cmd.bit_take) begin
         iter_in = iter_ff + 11'd1;
      end
      if (cmd.bit_take) begin
         acc_in[iter_ff[2:0]] = coil_rdata[0] & bvalid_ff;
      end
      if (cmd.reg_take) begin
         acc_in = jpos[0] ? hold_rdata[7:0] : hold_rdata[15:8];
      end
   end

   assign own_station_in = csr_wr_en ? csr_wr_data : own_station_ff;
   assign rsp_valid_in   = cmd.load_out | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         own_station_ff <= 8'd1;
         phase_ff       <= mrs_pkg::PH_STATION;
         station_ff     <= 8'h00;
         function_ff    <= 8'h00;
         address_ff     <= 16'h0000;
         count_ff       <= 16'h0000;
         total_ff       <= 8'h00;
         index_ff       <= 8'h00;
         rcrc_ff        <= mrs_pkg::CRC_INIT;
         kind_ff        <= mrs_pkg::KIND_NONE;
         pos_ff         <= 8'h00;
         xcrc_ff        <= mrs_pkg::CRC_INIT;
         iter_ff        <= 11'd0;
         clear_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         own_station_ff <= own_station_in;
         phase_ff       <= phase_in;
         station_ff     <= station_in;
         function_ff    <= function_in;
         address_ff     <= address_in;
         count_ff       <= count_in;
         total_ff       <= total_in;
         index_ff       <= index_in;
         rcrc_ff        <= rcrc_in;
         kind_ff        <= kind_in;
         pos_ff         <= pos_in;
         xcrc_ff        <= xcrc_in;
         iter_ff        <= iter_in;
         clear_ff       <= cmd.clear_step ? clear_ff + AW'(1) : clear_ff;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_data.op;
         rx_ff <= req_data.rx_byte;
      end
      if (cmd.cm_high) begin
         hold_ff <= pay_rdata;
      end
      if (cmd.bit_read) begin
         bvalid_ff <= (function_ff == mrs_pkg::FC_READ_COILS) && ({5'd0, bitnum} < count_ff);
      end
      if (cmd.load_out) begin
         rsp_data_ff <= res_ff;
      end
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   assign wr_coil1 = recv_act && do_commit && (function_ff == mrs_pkg::FC_WRITE_COIL) && !addr_out;
   assign wr_reg1  = recv_act && do_commit && (function_ff == mrs_pkg::FC_WRITE_REG) && !addr_out;

   always_comb begin
      hold_we    = cmd.clear_step | wr_reg1 | (cmd.cm_write & cm_regs);
      hold_waddr = address_ff[AW-1:0] + AW'(iter_ff);
      hold_wdata = {hold_ff, pay_rdata};
      coil_we    = cmd.clear_step | wr_coil1 | (cmd.cm_write & !cm_regs);
      coil_waddr = address_ff[AW-1:0] + AW'(iter_ff);
      coil_wdata = pay_rdata[iter_ff[2:0]];
      if (cmd.clear_step) begin
         hold_waddr = clear_ff;
         hold_wdata = 16'h0000;
         coil_waddr = clear_ff;
         coil_wdata = 1'b0;
      end else if (wr_reg1) begin
         hold_waddr = address_ff[AW-1:0];
         hold_wdata = count_ff;
      end else if (wr_coil1) begin
         coil_waddr = address_ff[AW-1:0];
         coil_wdata = count_ff[15:8] == mrs_pkg::COIL_ON;
      end
   end

   assign hold_raddr = address_ff[AW-1:0] + AW'(jpos[7:1]);
   assign coil_raddr = address_ff[AW-1:0] + AW'(bitnum);
   assign pay_we     = recv_act && (phase_ff == mrs_pkg::PH_DATA);
   assign pay_raddr  = cmd.cm_high ? {iter_ff[6:0], 1'b1} :
                       (cm_regs ? {iter_ff[6:0], 1'b0} : iter_ff[10:3]);

   mrs_ram #(.WIDTH(16), .DEPTH(AREA_WORDS)) u_holding (
      .clock   (clock),
      .wr_en   (hold_we),
      .wr_addr (hold_waddr),
      .wr_data (hold_wdata),
      .rd_addr (hold_raddr),
      .rd_data (hold_rdata)
   );

   mrs_ram #(.WIDTH(1), .DEPTH(AREA_WORDS)) u_coil (
      .clock   (clock),
      .wr_en   (coil_we),
      .wr_addr (coil_waddr),
      .wr_data (coil_wdata),
      .rd_addr (coil_raddr),
      .rd_data (coil_rdata)
   );

   mrs_ram #(.WIDTH(8), .DEPTH(256)) u_payload (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (index_ff),
      .wr_data (rx_ff),
      .rd_addr (pay_raddr),
      .rd_data (pay_rdata)
   );

   always_comb begin
      status.clear_last  = clear_ff == CLEAR_LAST;
      status.op          = op_ff;
      status.commit_loop = recv_act && do_commit && commit_kind == mrs_pkg::KIND_ECHO &&
                           (function_ff == mrs_pkg::FC_WRITE_COILS || cm_regs);
      status.kind_none   = kind_ff == mrs_pkg::KIND_NONE;
      status.need_bits   = kind_ff == mrs_pkg::KIND_BITS && pos_ff >= 8'd3 && pos_ff < len;
      status.need_reg    = kind_ff == mrs_pkg::KIND_REGS && pos_ff >= 8'd3 && pos_ff < len;
      status.cm_is_regs  = cm_regs;
      status.cm_last     = iter_ff == count_ff[10:0] - 11'd1;
      status.bit_last    = iter_ff[2:0] == 3'd7;
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

### sv/mrs_ctrl.sv
module mrs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  mrs_pkg::status_type  status,
   output mrs_pkg::cmd_type     cmd,
   output logic                 req_ready
);
   mrs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrs_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mrs_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = mrs_pkg::ST_IDLE;
         end
         mrs_pkg::ST_IDLE: begin
            if (req_valid) state_in = mrs_pkg::ST_DECODE;
         end
         mrs_pkg::ST_DECODE: begin
            if (!status.op) begin
               state_in = status.commit_loop ? mrs_pkg::ST_CM_ISSUE : mrs_pkg::ST_DONE;
            end else if (status.kind_none) begin
               state_in = mrs_pkg::ST_DONE;
            end else if (status.need_bits) begin
               state_in = mrs_pkg::ST_BIT_READ;
            end else if (status.need_reg) begin
               state_in = mrs_pkg::ST_REG_READ;
            end else begin
               state_in = mrs_pkg::ST_EMIT;
            end
         end
         mrs_pkg::ST_CM_ISSUE: begin
            state_in = status.cm_is_regs ? mrs_pkg::ST_CM_HIGH : mrs_pkg::ST_CM_WRITE;
         end
         mrs_pkg::ST_CM_HIGH:  state_in = mrs_pkg::ST_CM_WRITE;
         mrs_pkg::ST_CM_WRITE: begin
            state_in = status.cm_last ? mrs_pkg::ST_DONE : mrs_pkg::ST_CM_ISSUE;
         end
         mrs_pkg::ST_BIT_READ: state_in = mrs_pkg::ST_BIT_TAKE;
         mrs_pkg::ST_BIT_TAKE: begin
            state_in = status.bit_last ? mrs_pkg::ST_EMIT : mrs_pkg::ST_BIT_READ;
         end
         mrs_pkg::ST_REG_READ: state_in = mrs_pkg::ST_REG_TAKE;
         mrs_pkg::ST_REG_TAKE: state_in = mrs_pkg::ST_EMIT;
         mrs_pkg::ST_EMIT:     state_in = mrs_pkg::ST_DONE;
         mrs_pkg::ST_DONE: begin
            if (status.out_free) state_in = mrs_pkg::ST_IDLE;
         end
         default: state_in = mrs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         mrs_pkg::ST_CLEAR:    cmd.clear_step = 1'b1;
         mrs_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         mrs_pkg::ST_DECODE:   cmd.decode   = 1'b1;
         mrs_pkg::ST_CM_HIGH:  cmd.cm_high  = 1'b1;
         mrs_pkg::ST_CM_WRITE: cmd.cm_write = 1'b1;
         mrs_pkg::ST_BIT_READ: cmd.bit_read = 1'b1;
         mrs_pkg::ST_BIT_TAKE: cmd.bit_take = 1'b1;
         mrs_pkg::ST_REG_TAKE: cmd.reg_take = 1'b1;
         mrs_pkg::ST_EMIT:     cmd.emit     = 1'b1;
         mrs_pkg::ST_DONE:     cmd.load_out = status.out_free;
         default:              cmd          = '0;
      endcase
   end
endmodule

### test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mrs_pkg::*;

   localparam int AREA = 4096;
   localparam int IDLE_LIMIT = 40000;
   localparam int ITEM_GOAL = 1750;

   class modbus_scoreboard;
      bit [7:0]  own_station;
      phase_type phase;
      bit [7:0]  station, func;
      bit [15:0] addr, count;
      int        byte_total, byte_index;
      bit [15:0] frame_crc;
      bit [7:0]  payload [256];
      bit [15:0] holding [AREA];
      bit        coils [AREA];
      kind_type  kind;
      int        position;
      bit [15:0] reply_crc;
      rsp_type   expected_q [$];
      int        errors, replies, crc_fails, others;

      function new();
         own_station = 8'd1;
         phase = PH_STATION;
         station = 0; func = 0; addr = 0; count = 0;
         byte_total = 0; byte_index = 0;
         frame_crc = CRC_INIT;
         foreach (holding[i]) holding[i] = 0;
         foreach (coils[i]) coils[i] = 0;
         foreach (payload[i]) payload[i] = 0;
         kind = KIND_NONE; position = 0; reply_crc = CRC_INIT;
      endfunction

      function bit pending();
         return kind != KIND_NONE;
      endfunction

      function bit [15:0] crc_step(bit [15:0] c, bit [7:0] b);
         c = c ^ {8'h00, b};
         for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
         return c;
      endfunction

      function bit out_of_range(int a, int n, int lim);
         return n < 1 || n > lim || a + n > AREA;
      endfunction

      function void execute();
         int a, n;
         a = addr;
         n = count;
         case (func)
            FC_READ_COILS, FC_READ_DISCRETE:
               kind = out_of_range(a, n, 2000) ? KIND_EXC_ADDR : KIND_BITS;
            FC_READ_HOLDING, FC_READ_INPUT:
               kind = out_of_range(a, n, 125) ? KIND_EXC_ADDR : KIND_REGS;
            FC_WRITE_COIL: begin
               if (a >= AREA) kind = KIND_EXC_ADDR;
               else begin
                  coils[a] = (count[15:8] == COIL_ON);
                  kind = KIND_ECHO;
               end
            end
            FC_WRITE_REG: begin
               if (a >= AREA) kind = KIND_EXC_ADDR;
               else begin
                  holding[a] = count;
                  kind = KIND_ECHO;
               end
            end
            FC_WRITE_COILS: begin
               if (out_of_range(a, n, 1968)) kind = KIND_EXC_ADDR;
               else if (byte_total < (n + 7) / 8) kind = KIND_EXC_DATA;
               else begin
                  for (int i = 0; i < n; i++) coils[a + i] = payload[(i >> 3) & 255][i & 7];
                  kind = KIND_ECHO;
               end
            end
            FC_WRITE_REGS: begin
               if (out_of_range(a, n, 123)) kind = KIND_EXC_ADDR;
               else if (byte_total < 2 * n) kind = KIND_EXC_DATA;
               else begin
                  for (int i = 0; i < n; i++)
                     holding[a + i] = {payload[(2 * i) & 255], payload[(2 * i + 1) & 255]};
                  kind = KIND_ECHO;
               end
            end
            default: kind = KIND_EXC_FUNC;
         endcase
         position = 0;
         reply_crc = CRC_INIT;
      endfunction

      function bit [2:0] receive(bit [7:0] b);
         bit [2:0] ev;
         ev = EV_NONE;
         case (phase)
            PH_FUNCTION: begin
               if (b <= 8'd6 || b == FC_WRITE_COILS || b == FC_WRITE_REGS) begin
                  func = b;
                  frame_crc = crc_step(frame_crc, b);
                  phase = PH_HEADER;
                  byte_index = 0;
               end else begin
                  station = b;
                  frame_crc = crc_step(CRC_INIT, b);
                  ev = EV_SKIPPED;
               end
            end
            PH_HEADER: begin
               frame_crc = crc_step(frame_crc, b);
               case (byte_index)
                  0: addr = {b, 8'h00};
                  1: addr[7:0] = b;
                  2: count = {b, 8'h00};
                  default: count[7:0] = b;
               endcase
               byte_index++;
               if (byte_index >= 4) begin
                  byte_index = 0;
                  phase = (func == FC_WRITE_COILS || func == FC_WRITE_REGS) ? PH_COUNT : PH_CRC;
               end
            end
            PH_COUNT: begin
               frame_crc = crc_step(frame_crc, b);
               byte_total = b;
               byte_index = 0;
               phase = (b != 0) ? PH_DATA : PH_CRC;
            end
            PH_DATA: begin
               frame_crc = crc_step(frame_crc, b);
               payload[byte_index & 255] = b;
               byte_index++;
               if (byte_index >= byte_total) begin
                  byte_index = 0;
                  phase = PH_CRC;
               end
            end
            PH_CRC: begin
               frame_crc = crc_step(frame_crc, b);
               byte_index++;
               if (byte_index >= 2) begin
                  byte_index = 0;
                  phase = PH_STATION;
                  if (frame_crc != 0) begin
                     ev = EV_CRC; crc_fails++;
                  end else if (station != 0 && station != STATION_ANY && station != own_station)
                  begin
                     ev = EV_OTHER; others++;
                  end else begin
                     execute();
                     ev = EV_QUEUED; replies++;
                  end
               end
            end
            default: begin
               station = b;
               frame_crc = crc_step(CRC_INIT, b);
               phase = PH_FUNCTION;
            end
         endcase
         return ev;
      endfunction

      function int body_length();
         if (kind == KIND_BITS) return 3 + (int'(count) + 7) / 8;
         if (kind == KIND_REGS) return 3 + 2 * int'(count);
         if (kind == KIND_ECHO) return 6;
         return 3;
      endfunction

      function bit [7:0] body_byte(int p);
         int j, idx, bi;
         bit [7:0] v;
         v = 0;
         if (p == 0) return station;
         if (kind == KIND_EXC_FUNC || kind == KIND_EXC_ADDR || kind == KIND_EXC_DATA)
            return (p == 1) ? (func | EXC_FLAG) : 8'(kind);
         if (p == 1) return func;
         if (kind == KIND_ECHO) begin
            case (p)
               2: return addr[15:8];
               3: return addr[7:0];
               4: return count[15:8];
               default: return count[7:0];
            endcase
         end
         if (p == 2) return (kind == KIND_BITS) ? 8'((int'(count) + 7) / 8) : 8'(2 * int'(count));
         j = p - 3;
         if (kind == KIND_BITS) begin
            for (int k = 0; k < 8; k++) begin
               bi = j * 8 + k;
               idx = int'(addr) + bi;
               if (func == FC_READ_COILS && bi < count && idx < AREA) v[k] = coils[idx];
            end
            return v;
         end
         idx = int'(addr) + j / 2;
         if (idx >= AREA) return 0;
         return j[0] ? holding[idx][7:0] : holding[idx][15:8];
      endfunction

      function void note(req_type r);
         rsp_type e;
         int len;
         bit [7:0] b;
         e = '0;
         if (!r.op) begin
            e.event_res = pending() ? EV_BUSY : receive(r.rx_byte);
         end else if (pending()) begin
            len = body_length();
            e.tx_valid = 1;
            if (position < len) begin
               b = body_byte(position);
               reply_crc = crc_step(reply_crc, b);
               e.tx_byte = b;
               position++;
            end else if (position == len) begin
               e.tx_byte = reply_crc[7:0];
               position++;
            end else begin
               e.tx_byte = reply_crc[15:8];
               e.tx_last = 1;
               kind = KIND_NONE;
               position = 0;
            end
         end
         expected_q.push_back(e);
      endfunction

      function void check(rsp_type a);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $error("response with no request outstanding: %h", a);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (a.tx_valid !== e.tx_valid) begin
            $error("tx_valid expected %0d actual %0d", e.tx_valid, a.tx_valid); errors++;
         end
         if (a.tx_byte !== e.tx_byte) begin
            $error("tx_byte expected %h actual %h", e.tx_byte, a.tx_byte); errors++;
         end
         if (a.tx_last !== e.tx_last) begin
            $error("tx_last expected %0d actual %0d", e.tx_last, a.tx_last); errors++;
         end
         if (a.event_res !== e.event_res) begin
            $error("event_res expected %0d actual %0d", e.event_res, a.event_res); errors++;
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;
   logic    csr_wr_en = 0;
   logic [7:0] csr_wr_data = 0;

   modbus_scoreboard sb = new();
   int items = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   bit steady = 0;

   modbus_rtu_slave_engine #(.AREA_WORDS(AREA)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_data);
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL modbus_rtu_slave_engine");
         $finish;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (steady) begin
         rsp_stall <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1;
         stall_left <= stall_left - 1;
      end else if ($urandom % 5 == 0) begin
         rsp_stall <= 1;
         stall_left <= ($urandom % 12 == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end else begin
         rsp_stall <= 0;
      end
   end

   task automatic push(bit op, bit [7:0] b);
      int gap;
      req_type r;
      gap = 0;
      if (!steady && $urandom % 3 == 0)
         gap = ($urandom % 10 == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      r.op = op;
      r.rx_byte = b;
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note(r);
      items++;
   endtask

   task automatic drain();
      while (sb.pending()) begin
         if ($urandom % 10 == 0) push(0, 8'($urandom));
         else push(1, 8'($urandom));
      end
   endtask

   task automatic send_frame(bit [7:0] st, bit [7:0] fc, bit [15:0] a, bit [15:0] n,
                             int total, bit corrupt);
      bit [7:0] bytes [$];
      bit [15:0] c;
      bytes = '{st, fc, a[15:8], a[7:0], n[15:8], n[7:0]};
      if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) begin
         bytes.push_back(8'(total));
         repeat (total) bytes.push_back(8'($urandom));
      end
      c = CRC_INIT;
      foreach (bytes[i]) c = sb.crc_step(c, bytes[i]);
      if (corrupt) c[$urandom % 16] ^= 1'b1;
      bytes.push_back(c[7:0]);
      bytes.push_back(c[15:8]);
      foreach (bytes[i]) push(0, bytes[i]);
      drain();
   endtask

   task automatic set_station(bit [7:0] v);
      req_valid <= 0;
      wait (sb.expected_q.size() == 0);
      repeat (50) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.own_station = v;
   endtask

   task automatic random_frame();
      bit [7:0] st, fc;
      bit [15:0] a, n;
      int total, sel;
      sel = $urandom % 10;
      st = (sel < 5) ? sb.own_station : (sel < 7) ? 8'd0 : (sel < 8) ? STATION_ANY
           : 8'($urandom);
      case ($urandom % 10)
         0: fc = FC_READ_COILS;
         1: fc = FC_READ_DISCRETE;
         2: fc = FC_READ_HOLDING;
         3: fc = FC_READ_INPUT;
         4: fc = FC_WRITE_COIL;
         5: fc = FC_WRITE_REG;
         6, 7: fc = FC_WRITE_COILS;
         8: fc = FC_WRITE_REGS;
         default: fc = ($urandom % 2) ? 8'd0 : 8'($urandom);
      endcase
      a = ($urandom % 8 == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      if ($urandom % 6 == 0) a = 16'($urandom_range(AREA - 20, AREA + 5));
      n = ($urandom % 10 == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
      if (fc == FC_WRITE_COIL || fc == FC_WRITE_REG) n = 16'($urandom);
      total = (fc == FC_WRITE_COILS) ? (int'(n) + 7) / 8 : 2 * int'(n);
      if (total > 255 || $urandom % 6 == 0) total = $urandom_range(0, 40);
      else if ($urandom % 6 == 0) total = total + $urandom_range(1, 3);
      if (total > 255) total = 255;
      send_frame(st, fc, a, n, total, $urandom % 12 == 0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;

      set_station(8'd1);
      steady = 1;
      push(1, 8'h00);
      send_frame(8'd1, FC_WRITE_REGS, 16'd0, 16'd123, 246, 0);
      steady = 0;
      send_frame(8'd0, FC_READ_HOLDING, 16'd0, 16'd125, 0, 0);
      send_frame(STATION_ANY, FC_WRITE_COILS, 16'd0, 16'd1968, 246, 0);
      send_frame(8'd1, FC_READ_COILS, 16'd0, 16'd2000, 0, 0);
      send_frame(8'd1, FC_READ_DISCRETE, 16'd4080, 16'd16, 0, 0);
      send_frame(8'd1, FC_READ_INPUT, 16'd4095, 16'd1, 0, 0);
      send_frame(8'd1, FC_WRITE_COIL, 16'd4095, 16'hFF00, 0, 0);
      send_frame(8'd1, FC_WRITE_COIL, 16'd4096, 16'h00FF, 0, 0);
      send_frame(8'd1, FC_WRITE_REG, 16'hFFFF, 16'hFFFF, 0, 0);
      send_frame(8'd1, FC_READ_HOLDING, 16'd0, 16'd0, 0, 0);
      send_frame(8'd1, FC_WRITE_REGS, 16'd10, 16'd4, 3, 0);
      send_frame(8'd1, FC_WRITE_COILS, 16'd10, 16'd9, 0, 0);
      send_frame(8'd1, 8'h00, 16'd0, 16'd1, 0, 0);
      send_frame(8'd1, 8'h2B, 16'h1234, 16'h5678, 0, 0);
      send_frame(8'd9, FC_READ_HOLDING, 16'd0, 16'd1, 0, 0);
      send_frame(8'd1, FC_READ_HOLDING, 16'd0, 16'd1, 0, 1);

      set_station(8'd247);
      while (items < ITEM_GOAL) begin
         if (items % 400 < 20 && $urandom % 4 == 0) begin
            set_station(($urandom % 3 == 0) ? 8'd1 : 8'($urandom_range(1, 247)));
         end
         steady = (items % 600) < 60;
         if ($urandom % 8 == 0) push($urandom % 2, 8'($urandom));
         else random_frame();
      end
      set_station(8'd247);
      send_frame(8'd247, FC_READ_COILS, 16'd0, 16'd16, 0, 0);

      req_valid <= 0;
      wait (sb.expected_q.size() == 0);
      repeat (100) @(posedge clock);
      $display("covered %0d requests: %0d replies, %0d crc rejects, %0d other-station frames",
               items, sb.replies, sb.crc_fails, sb.others);
      if (sb.errors == 0 && sb.expected_q.size() == 0) $display("PASS modbus_rtu_slave_engine");
      else $display("FAIL modbus_rtu_slave_engine");
      $finish;
   end
endmodule
